// File: src/bdq_pkg.sv
package bdq_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned DEF_MAX_DEPTH = 16;

  localparam logic [CNT_W-1:0]  CAP_RESET   = CNT_W'(16);
  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_e;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

endpackage

// File: src/bdq_if.sv
interface bdq_req_if;
  import bdq_pkg::*;

  logic  valid;
  logic  ready;
  kind_e kind;
  data_t push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink (input valid, input kind, input push_value, output ready);
endinterface

interface bdq_rsp_if;
  import bdq_pkg::*;

  logic  valid;
  logic  ready;
  data_t front_value;
  data_t back_value;
  cnt_t  entry_count;
  logic  op_error;

  modport source (
    output valid, output front_value, output back_value, output entry_count,
    output op_error, input ready
  );
  modport sink (
    input valid, input front_value, input back_value, input entry_count,
    input op_error, output ready
  );
endinterface

// File: src/bounded_double_ended_queue_unit.sv
// Channel  | Dir | Payload                                          | Handshake
// req_i    | in  | kind, push_value                                 | valid/ready
// rsp_o    | out | front_value, back_value, entry_count, op_error   | valid/ready
// cfg      | in  | cfg_wdata_i (capacity_limit)                     | cfg_we_i
//
// One item per cycle unless stalled; results pass pending, then output regs.
// The slot memory has one write and one read port, both used at acceptance;
// a pop that leaves two or more entries reads its new end through rd_q.
// Reset clears pointers, count and control; capacity returns to 16. The slot
// memory is not cleared and needs no clearing pass.
// One item waits behind a stalled output register; ready drops after that.
module bounded_double_ended_queue_unit #(
  parameter int unsigned MAX_DEPTH = bdq_pkg::DEF_MAX_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [bdq_pkg::CNT_W-1:0] cfg_wdata_i,
  bdq_req_if.sink                 req_i,
  bdq_rsp_if.source               rsp_o
);
  import bdq_pkg::*;

  localparam int unsigned IdxW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_DEPTH - 1);

  logic [DATA_W-1:0] mem_q [MAX_DEPTH];
  data_t             rd_q;

  cnt_t            capacity_q;
  logic [IdxW-1:0] front_idx_q, front_idx_d;
  logic [IdxW-1:0] back_idx_q, back_idx_d;
  cnt_t            count_q, count_d;
  data_t           front_val_q, back_val_q;
  data_t           front_val_d, back_val_d;
  logic            upd_q;

  logic  pend_q;
  data_t p_front_q, p_back_q;
  logic  p_from_front_q, p_from_back_q;
  cnt_t  p_count_q;
  logic  p_err_q;

  logic  out_valid_q;
  data_t out_front_q, out_back_q;
  cnt_t  out_count_q;
  logic  out_err_q;

  logic            acc, move;
  cnt_t            limit;
  data_t           eff_front, eff_back;
  logic            err_d, from_front_d, from_back_d;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;

  function automatic logic [IdxW-1:0] wrap_up(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] wrap_down(input logic [IdxW-1:0] i);
    return (i == '0) ? LastIdx : i - IdxW'(1);
  endfunction

  assign move        = pend_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !pend_q || move;
  assign acc         = req_i.valid && req_i.ready;

  assign limit = (32'(capacity_q) > 32'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH) : capacity_q;

  assign eff_front = (upd_q && p_from_front_q) ? rd_q : front_val_q;
  assign eff_back  = (upd_q && p_from_back_q) ? rd_q : back_val_q;

  always_comb begin
    front_idx_d  = front_idx_q;
    back_idx_d   = back_idx_q;
    count_d      = count_q;
    front_val_d  = eff_front;
    back_val_d   = eff_back;
    err_d        = 1'b0;
    from_front_d = 1'b0;
    from_back_d  = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = front_idx_q;
    mem_raddr    = front_idx_q;
    unique case (req_i.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (count_q >= limit) begin
          err_d = 1'b1;
        end else begin
          mem_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
          if (count_q == '0) begin
            back_idx_d  = front_idx_q;
            mem_waddr   = front_idx_q;
            front_val_d = req_i.push_value;
            back_val_d  = req_i.push_value;
          end else if (req_i.kind == KIND_PUSH_FRONT) begin
            front_idx_d = wrap_down(front_idx_q);
            mem_waddr   = front_idx_d;
            front_val_d = req_i.push_value;
          end else begin
            back_idx_d = wrap_up(back_idx_q);
            mem_waddr  = back_idx_d;
            back_val_d = req_i.push_value;
          end
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (count_q == '0) begin
          err_d = 1'b1;
        end else begin
          count_d = count_q - CNT_W'(1);
          if (count_q > CNT_W'(1)) begin
            if (req_i.kind == KIND_POP_FRONT) begin
              front_idx_d = wrap_up(front_idx_q);
              if (count_q == CNT_W'(2)) begin
                front_val_d = eff_back;
              end else begin
                mem_re       = 1'b1;
                mem_raddr    = front_idx_d;
                from_front_d = 1'b1;
              end
            end else begin
              back_idx_d = wrap_down(back_idx_q);
              if (count_q == CNT_W'(2)) begin
                back_val_d = eff_front;
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = back_idx_d;
                from_back_d = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        err_d = 1'b0;
      end
    endcase
    if (count_d == '0) begin
      front_val_d = EMPTY_VALUE;
      back_val_d  = EMPTY_VALUE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && mem_we) begin
      mem_q[mem_waddr] <= req_i.push_value;
    end
    if (acc && mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CAP_RESET;
      front_idx_q <= '0;
      back_idx_q  <= '0;
      count_q     <= '0;
      front_val_q <= EMPTY_VALUE;
      back_val_q  <= EMPTY_VALUE;
      upd_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      upd_q <= acc;
      if (acc) begin
        front_idx_q <= front_idx_d;
        back_idx_q  <= back_idx_d;
        count_q     <= count_d;
        front_val_q <= front_val_d;
        back_val_q  <= back_val_d;
      end else if (upd_q) begin
        front_val_q <= eff_front;
        back_val_q  <= eff_back;
      end
      if (acc) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      p_front_q      <= front_val_d;
      p_back_q       <= back_val_d;
      p_from_front_q <= from_front_d;
      p_from_back_q  <= from_back_d;
      p_count_q      <= count_d;
      p_err_q        <= err_d;
    end
    if (move) begin
      out_front_q <= p_from_front_q ? rd_q : p_front_q;
      out_back_q  <= p_from_back_q ? rd_q : p_back_q;
      out_count_q <= p_count_q;
      out_err_q   <= p_err_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.front_value = out_front_q;
  assign rsp_o.back_value  = out_back_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.op_error    = out_err_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_DEPTH)
    else $error("count exceeds slot memory depth");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> pend_q && out_valid_q && !rsp_o.ready)
    else $error("input stalled without a held result");

  a_empty_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.entry_count == '0 |->
      rsp_o.front_value == EMPTY_VALUE && rsp_o.back_value == EMPTY_VALUE)
    else $error("empty queue reports stored values");

  a_pend_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !move |=> pend_q && $stable(p_count_q) && $stable(rd_q))
    else $error("pending item lost while output stalled");

endmodule
